FILE: design/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and codes for the ping-pong DMA channel.
// ----------------------------------------------------------------------------
package dpc_pkg;

  typedef enum logic [2:0] {
    OP_FEED = 3'd0,
    OP_TX   = 3'd1,
    OP_POLL = 3'd2,
    OP_CAPT = 3'd3,
    OP_RDRX = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_TXEV = 2'd1,
    KIND_RXEV = 2'd2,
    KIND_DATA = 2'd3
  } kind_e;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_PERIPH   = 2'd1;
  localparam logic [1:0] CFG_LOOPBACK = 2'd2;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       first;
    logic [9:0] blen;
    logic       sel;
    logic [7:0] off;
    logic       in_range;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [8:0]  length;
    logic [15:0] seq;
    logic        bidx;
    logic [7:0]  periph;
    logic [7:0]  data;
    logic        last;
  } res_t;

endpackage

FILE: design/dpc_front.sv
// ----------------------------------------------------------------------------
// dpc_front
// Input beat decode: drops unknown ops, flags rx read offsets in range.
// ----------------------------------------------------------------------------
module dpc_front #(
  parameter int BUF_SIZE = 256
) (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     op_i,
  input  logic [7:0]     data_in_i,
  input  logic           first_i,
  input  logic [9:0]     batch_len_i,
  input  logic           rx_buffer_i,
  input  logic [7:0]     offset_i,
  output logic           cmd_valid_o,
  output dpc_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);
  import dpc_pkg::*;

  logic known;

  always_comb begin
    known     = 1'b1;
    cmd_o.op  = OP_FEED;
    unique case (op_i)
      3'd0: cmd_o.op = OP_FEED;
      3'd1: cmd_o.op = OP_TX;
      3'd2: cmd_o.op = OP_POLL;
      3'd3: cmd_o.op = OP_CAPT;
      3'd4: cmd_o.op = OP_RDRX;
      default: known = 1'b0;
    endcase
    cmd_o.data     = data_in_i;
    cmd_o.first    = first_i;
    cmd_o.blen     = batch_len_i;
    cmd_o.sel      = rx_buffer_i;
    cmd_o.off      = offset_i;
    cmd_o.in_range = (32'(offset_i) < 32'(BUF_SIZE));
  end

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && known;

endmodule

FILE: design/dpc_queue.sv
// ----------------------------------------------------------------------------
// dpc_queue
// Two-entry command queue between decode and execution.
// ----------------------------------------------------------------------------
module dpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  dpc_pkg::cmd_t  push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output dpc_pkg::cmd_t  pop_cmd_o,
  input  logic           pop_ready_i
);
  import dpc_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = ent_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= push_cmd_i;
    end
  end

endmodule

FILE: design/dpc_back.sv
// ----------------------------------------------------------------------------
// dpc_back
// Execution: rings, tx store, rx buffers, poll sequencer, result register.
// ----------------------------------------------------------------------------
module dpc_back #(
  parameter int BUF_SIZE  = 256,
  parameter int STAGE_CAP = 768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           cmd_valid_i,
  input  dpc_pkg::cmd_t  cmd_i,
  output logic           cmd_ready_o,
  output logic           res_valid_o,
  output dpc_pkg::res_t  res_o,
  input  logic           res_ready_i
);
  import dpc_pkg::*;

  localparam int AW = $clog2(STAGE_CAP);
  localparam int CW = $clog2(STAGE_CAP + 1);
  localparam int BW = $clog2(BUF_SIZE);
  localparam int TW = $clog2(BUF_SIZE + 1);
  localparam int RW = BW + 1;
  localparam int XW = ((CW > 10) ? CW : 10) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TXRD = 4'd1;
  localparam logic [3:0] S_TXWR = 4'd2;
  localparam logic [3:0] S_TXEV = 4'd3;
  localparam logic [3:0] S_RXRD = 4'd4;
  localparam logic [3:0] S_RXWR = 4'd5;
  localparam logic [3:0] S_RXEV = 4'd6;
  localparam logic [3:0] S_CAPT = 4'd7;
  localparam logic [3:0] S_RDRX = 4'd8;

  logic [7:0] ing_mem [STAGE_CAP];
  logic [7:0] egr_mem [STAGE_CAP];
  logic [7:0] tx_mem  [BUF_SIZE];
  logic [7:0] rx_mem  [2*BUF_SIZE];

  logic          ing_we, egr_we, tx_we, rx_we;
  logic [AW-1:0] ing_wa, egr_wa, ing_ra, egr_ra;
  logic [BW-1:0] tx_wa, tx_ra;
  logic [RW-1:0] rx_wa, rx_ra;
  logic [7:0]    ing_wd, tx_wd, rx_wd;
  logic          ing_re, egr_re, tx_re, rx_re;
  logic [7:0]    ing_rd_q, egr_rd_q, tx_rd_q, rx_rd_q;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] ing_head_q, ing_head_d, egr_head_q, egr_head_d;
  logic [CW-1:0] ing_cnt_q, ing_cnt_d, egr_cnt_q, egr_cnt_d;
  logic [TW-1:0] tx_cnt_q, tx_cnt_d, idx_q, idx_d, fill_q, fill_d;
  logic          tx_pend_q, tx_pend_d, rx_side_q, rx_side_d;
  logic [15:0]   seq_q, seq_d;
  logic          bat_acc_q, bat_acc_d, bat_tx_q, bat_tx_d;
  logic [9:0]    bat_rem_q, bat_rem_d;
  logic          en_q, en_d, lb_q, lb_d, lb_go_q, lb_go_d, eg_go_q, eg_go_d;
  logic [7:0]    pid_q, pid_d;
  res_t          res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic          out_free, emit, is_tx, acc, do_store;
  logic [XW-1:0] blen_x, used_x, txc_x;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(STAGE_CAP)) s = s - (CW+1)'(STAGE_CAP);
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] inc_head(logic [AW-1:0] a);
    return (a == AW'(STAGE_CAP - 1)) ? '0 : a + 1'b1;
  endfunction

  assign out_free    = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    ing_head_d = ing_head_q; ing_cnt_d = ing_cnt_q;
    egr_head_d = egr_head_q; egr_cnt_d = egr_cnt_q;
    tx_cnt_d = tx_cnt_q; tx_pend_d = tx_pend_q; idx_d = idx_q; fill_d = fill_q;
    rx_side_d = rx_side_q; seq_d = seq_q;
    bat_acc_d = bat_acc_q; bat_tx_d = bat_tx_q; bat_rem_d = bat_rem_q;
    en_d = en_q; lb_d = lb_q; pid_d = pid_q; lb_go_d = lb_go_q; eg_go_d = eg_go_q;
    ing_we = 1'b0; egr_we = 1'b0; tx_we = 1'b0; rx_we = 1'b0;
    ing_wa = wrap_add(ing_head_q, ing_cnt_q);
    egr_wa = wrap_add(egr_head_q, egr_cnt_q);
    ing_wd = cmd_i.data; tx_wd = cmd_i.data; rx_wd = ing_rd_q;
    tx_wa = BW'(tx_cnt_q);
    rx_wa = rx_side_q ? RW'(BUF_SIZE) + RW'(fill_q) : RW'(fill_q);
    ing_ra = ing_head_q; egr_ra = egr_head_q; tx_ra = BW'(idx_q);
    rx_ra = cmd_i.sel ? RW'(BUF_SIZE) + RW'(cmd_i.off) : RW'(cmd_i.off);
    ing_re = 1'b0; egr_re = 1'b0; tx_re = 1'b0; rx_re = 1'b0;
    emit = 1'b0; is_tx = 1'b0; acc = 1'b0; do_store = 1'b0;
    blen_x = XW'(cmd_i.blen);
    used_x = XW'(ing_cnt_q) + ((bat_acc_q && !bat_tx_q) ? XW'(bat_rem_q) : '0);
    txc_x  = XW'(tx_cnt_q);
    res_d = '{kind: KIND_ACK, ok: 1'b0, length: '0, seq: '0, bidx: 1'b0,
              periph: pid_q, data: '0, last: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          unique case (cmd_i.op)
            OP_FEED, OP_TX: begin
              is_tx = (cmd_i.op == OP_TX);
              if (cmd_i.first) begin
                bat_acc_d = 1'b0;
                bat_rem_d = '0;
                if (is_tx) begin
                  acc = en_q && (cmd_i.blen != '0) && (blen_x <= XW'(BUF_SIZE)) && !tx_pend_q;
                end else begin
                  acc = en_q && (blen_x <= XW'(STAGE_CAP) - XW'(ing_cnt_q));
                end
                emit = 1'b1;
                res_d.ok = acc;
                res_d.last = 1'b1;
                if (acc && cmd_i.blen != '0) begin
                  bat_acc_d = 1'b1;
                  bat_tx_d  = is_tx;
                  bat_rem_d = cmd_i.blen;
                  if (is_tx) tx_cnt_d = '0;
                  do_store = 1'b1;
                end
              end else if (en_q && bat_acc_q && (bat_tx_q == is_tx)) begin
                do_store = 1'b1;
              end
              if (do_store) begin
                if (bat_tx_d) begin
                  if (tx_cnt_d < TW'(BUF_SIZE)) begin
                    tx_we    = 1'b1;
                    tx_wa    = BW'(tx_cnt_d);
                    tx_cnt_d = tx_cnt_d + 1'b1;
                  end
                end else if (ing_cnt_q < CW'(STAGE_CAP)) begin
                  ing_we    = 1'b1;
                  ing_cnt_d = ing_cnt_q + 1'b1;
                end
                if (bat_rem_d != '0) bat_rem_d = bat_rem_d - 1'b1;
                if (bat_rem_d == '0) begin
                  bat_acc_d = 1'b0;
                  if (bat_tx_d) tx_pend_d = 1'b1;
                end
              end
            end
            OP_POLL: begin
              if (en_q) begin
                if (tx_pend_q) begin
                  idx_d   = '0;
                  lb_go_d = lb_q && (used_x <= XW'(STAGE_CAP)) &&
                            (txc_x <= XW'(STAGE_CAP) - used_x);
                  eg_go_d = (txc_x <= XW'(STAGE_CAP) - XW'(egr_cnt_q));
                  state_d = S_TXRD;
                end else if (ing_cnt_q != '0) begin
                  fill_d  = '0;
                  state_d = S_RXRD;
                end
              end
            end
            OP_CAPT: begin
              if (en_q && egr_cnt_q != '0) begin
                egr_re     = 1'b1;
                egr_head_d = inc_head(egr_head_q);
                egr_cnt_d  = egr_cnt_q - 1'b1;
                state_d    = S_CAPT;
              end else begin
                emit = 1'b1;
                res_d.kind = KIND_DATA;
                res_d.last = 1'b1;
              end
            end
            OP_RDRX: begin
              if (cmd_i.in_range) begin
                rx_re   = 1'b1;
                state_d = S_RDRX;
              end else begin
                emit = 1'b1;
                res_d.kind = KIND_DATA;
                res_d.last = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_TXRD: begin
        tx_re   = 1'b1;
        state_d = S_TXWR;
      end
      S_TXWR: begin
        ing_wd = tx_rd_q;
        if (lb_go_q) begin
          ing_we    = 1'b1;
          ing_cnt_d = ing_cnt_q + 1'b1;
        end
        if (eg_go_q) begin
          egr_we    = 1'b1;
          egr_cnt_d = egr_cnt_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ((idx_q + 1'b1) == tx_cnt_q) ? S_TXEV : S_TXRD;
      end
      S_TXEV: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.kind = KIND_TXEV;
          res_d.ok = 1'b1;
          res_d.length = 9'(tx_cnt_q);
          res_d.seq = seq_q;
          res_d.last = (ing_cnt_q == '0);
          seq_d = seq_q + 1'b1;
          tx_pend_d = 1'b0;
          tx_cnt_d = '0;
          fill_d = '0;
          state_d = (ing_cnt_q != '0) ? S_RXRD : S_IDLE;
        end
      end
      S_RXRD: begin
        ing_re  = 1'b1;
        state_d = S_RXWR;
      end
      S_RXWR: begin
        rx_we      = 1'b1;
        ing_head_d = inc_head(ing_head_q);
        ing_cnt_d  = ing_cnt_q - 1'b1;
        fill_d     = fill_q + 1'b1;
        if ((fill_q + 1'b1) == TW'(BUF_SIZE) || ing_cnt_q == CW'(1)) begin
          state_d = S_RXEV;
        end else begin
          state_d = S_RXRD;
        end
      end
      S_RXEV: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.kind = KIND_RXEV;
          res_d.ok = 1'b1;
          res_d.length = 9'(fill_q);
          res_d.seq = seq_q;
          res_d.bidx = rx_side_q;
          res_d.last = (ing_cnt_q == '0);
          seq_d = seq_q + 1'b1;
          rx_side_d = ~rx_side_q;
          fill_d = '0;
          state_d = (ing_cnt_q != '0) ? S_RXRD : S_IDLE;
        end
      end
      S_CAPT: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.kind = KIND_DATA;
          res_d.ok = 1'b1;
          res_d.data = egr_rd_q;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RDRX: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.kind = KIND_DATA;
          res_d.ok = 1'b1;
          res_d.data = rx_rd_q;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: begin
          if (cfg_wdata_i[0] && !en_q) begin
            ing_head_d = '0; ing_cnt_d = '0; egr_head_d = '0; egr_cnt_d = '0;
            tx_cnt_d = '0; tx_pend_d = 1'b0; rx_side_d = 1'b0; seq_d = '0;
            bat_tx_d = 1'b0;
          end
          if (!cfg_wdata_i[0] || !en_q) begin
            bat_acc_d = 1'b0;
            bat_rem_d = '0;
          end
          en_d = cfg_wdata_i[0];
        end
        CFG_PERIPH:   pid_d = cfg_wdata_i;
        CFG_LOOPBACK: lb_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    res_valid_d = emit ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ing_head_q <= '0; ing_cnt_q <= '0; egr_head_q <= '0; egr_cnt_q <= '0;
      tx_cnt_q <= '0; tx_pend_q <= 1'b0; idx_q <= '0; fill_q <= '0;
      rx_side_q <= 1'b0; seq_q <= '0;
      bat_acc_q <= 1'b0; bat_tx_q <= 1'b0; bat_rem_q <= '0;
      en_q <= 1'b0; lb_q <= 1'b0; pid_q <= '0; lb_go_q <= 1'b0; eg_go_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ing_head_q <= ing_head_d; ing_cnt_q <= ing_cnt_d;
      egr_head_q <= egr_head_d; egr_cnt_q <= egr_cnt_d;
      tx_cnt_q <= tx_cnt_d; tx_pend_q <= tx_pend_d; idx_q <= idx_d; fill_q <= fill_d;
      rx_side_q <= rx_side_d; seq_q <= seq_d;
      bat_acc_q <= bat_acc_d; bat_tx_q <= bat_tx_d; bat_rem_q <= bat_rem_d;
      en_q <= en_d; lb_q <= lb_d; pid_q <= pid_d; lb_go_q <= lb_go_d; eg_go_q <= eg_go_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (ing_we) ing_mem[ing_wa] <= ing_wd;
    if (ing_re) ing_rd_q <= ing_mem[ing_ra];
  end

  always_ff @(posedge clk_i) begin
    if (egr_we) egr_mem[egr_wa] <= tx_rd_q;
    if (egr_re) egr_rd_q <= egr_mem[egr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    if (tx_re) tx_rd_q <= tx_mem[tx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_wa] <= rx_wd;
    if (rx_re) rx_rd_q <= rx_mem[rx_ra];
  end

endmodule

FILE: design/dma_pingpong_channel_model_core.sv
// ----------------------------------------------------------------------------
// dma_pingpong_channel_model_core
// DMA channel with feed/tx batches, egress capture ring, loopback and
// ping-pong rx buffers.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   in      | in_valid_i/in_ready_o  | op, data_in, first, batch_len, rx_buffer, offset
//   out     | out_valid_o/out_ready_i| kind, ok, length, seq, buffer_index, periph_out,
//           |                        | data_out, last
//   cfg     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Feed/tx beats and non-read ops are handled in the execution sequencer's idle
// state; capture and rx read first pass through a registered memory read.
// A poll dispatches from idle, then steps each tx byte and each ingress byte
// through a read and a write state and emits each event from its own state.
// A two-entry queue lets input beats arrive while a poll runs.
// Reset clears all control state; ring and buffer contents are not cleared.
// ----------------------------------------------------------------------------
module dma_pingpong_channel_model_core #(
  parameter int BUF_SIZE  = 256,
  parameter int STAGE_CAP = 768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_in_i,
  input  logic        first_i,
  input  logic [9:0]  batch_len_i,
  input  logic        rx_buffer_i,
  input  logic [7:0]  offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        ok_o,
  output logic [8:0]  length_o,
  output logic [15:0] seq_o,
  output logic        buffer_index_o,
  output logic [7:0]  periph_out_o,
  output logic [7:0]  data_out_o,
  output logic        last_o
);
  import dpc_pkg::*;

  logic fr_valid, fr_ready, q_valid, q_ready;
  cmd_t fr_cmd, q_cmd;
  res_t res;

  dpc_front #(.BUF_SIZE(BUF_SIZE)) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .data_in_i  (data_in_i),
    .first_i    (first_i),
    .batch_len_i(batch_len_i),
    .rx_buffer_i(rx_buffer_i),
    .offset_i   (offset_i),
    .cmd_valid_o(fr_valid),
    .cmd_o      (fr_cmd),
    .cmd_ready_i(fr_ready)
  );

  dpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_cmd_i  (fr_cmd),
    .push_ready_o(fr_ready),
    .pop_valid_o (q_valid),
    .pop_cmd_o   (q_cmd),
    .pop_ready_i (q_ready)
  );

  dpc_back #(.BUF_SIZE(BUF_SIZE), .STAGE_CAP(STAGE_CAP)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_ready_o(q_ready),
    .res_valid_o(out_valid_o),
    .res_o      (res),
    .res_ready_i(out_ready_i)
  );

  assign kind_o         = res.kind;
  assign ok_o           = res.ok;
  assign length_o       = res.length;
  assign seq_o          = res.seq;
  assign buffer_index_o = res.bidx;
  assign periph_out_o   = res.periph;
  assign data_out_o     = res.data;
  assign last_o         = res.last;

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |-> length_o == '0 && seq_o == '0)
    else $error("read beat carries event fields");

  a_event_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TXEV || kind_o == KIND_RXEV) |-> ok_o && length_o != '0)
    else $error("event beat without ok or length");

  a_nok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> data_out_o == '0 && length_o == '0)
    else $error("rejected beat carries data");

endmodule
